[rtl/core/duc_pkg.sv]
// duc_pkg: shared types and constants of the distinct unit counter
// used by duc_ctrl, duc_datapath and distinct_unit_counter
// no dependencies
package duc_pkg;

	// field widths fixed by the interface
	localparam int DATA_W    = 8;
	localparam int PROC_W    = 32;
	localparam int DIST_W    = 17;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int USIZE_W   = 2;

	// bitmap row geometry: 64 map bits per memory word
	localparam int ROW_LG = 6;
	localparam int ROW_W  = 1 << ROW_LG;

	// saturation value of the processed unit count
	localparam logic [PROC_W-1:0] PROCESSED_SAT = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT = 1'd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;      // input transfer this cycle
		logic insert;      // finish bitmap read-modify-write
		logic emit;        // load result register, clear counters
		logic clear_step;  // zero one bitmap row
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic unit_done;   // current input byte completes a unit
		logic clear_last;  // clear pass is at the last row
		logic out_full;    // result register holds an untaken result
	} ctl_sts_t;

endpackage

[rtl/core/duc_ctrl.sv]
// duc_ctrl: sequencing state machine of the distinct unit counter
// drives input stall and datapath commands
// depends on duc_pkg
module duc_ctrl
	import duc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     end_of_stream,
	output logic     in_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;
	localparam logic [1:0] ST_CLEAR  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       eos_q;
	logic       accept;

	// input is taken only when idle; an end marker also needs a free result slot
	assign in_stall = (state_q != ST_IDLE) || (sts.out_full && end_of_stream);
	assign accept   = in_valid && !in_stall;

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.insert     = (state_q == ST_INSERT);
		cmd.emit       = (state_q == ST_EMIT);
		cmd.clear_step = (state_q == ST_CLEAR);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.unit_done) begin
						state_d = ST_INSERT;
					end else if (end_of_stream) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_INSERT: begin
				state_d = eos_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register; reset starts with a clear pass over the bitmap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			eos_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				eos_q <= end_of_stream;
			end
		end
	end

endmodule

[rtl/core/duc_datapath.sv]
// duc_datapath: unit packing, bitmap memory, counters and result register
// depends on duc_pkg; commanded by duc_ctrl
module duc_datapath
	import duc_pkg::*;
#(
	parameter int UNIT_BYTES_MAX = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [DATA_W-1:0]    data_byte,
	input  logic                 byte_valid,
	input  ctl_cmd_t             cmd,
	output ctl_sts_t             sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [PROC_W-1:0]    units_processed,
	output logic [DIST_W-1:0]    distinct_units,
	output logic                 limit_hit
);

	localparam int MAP_LG = DATA_W * UNIT_BYTES_MAX;
	localparam int ROW_AW = MAP_LG - ROW_LG;
	localparam int ROWS   = 1 << ROW_AW;
	localparam int CMP_W  = (MAP_LG > DIST_W) ? MAP_LG : DIST_W;

	// configuration registers
	logic [USIZE_W-1:0] usize_q;
	logic [CFG_W-1:0]   stop_limit_q;

	// stream state
	logic [MAP_LG-1:0] partial_q;
	logic [1:0]        pos_q;
	logic [PROC_W-1:0] processed_q;
	logic [DIST_W-1:0] distinct_q;
	logic              stopped_q;
	logic [ROW_AW-1:0] clr_addr_q;
	logic              out_valid_q;

	// insert pipeline
	logic [MAP_LG-1:0] idx_s1;
	logic [ROW_W-1:0]  row_s1;

	// bitmap
	logic [ROW_W-1:0] map_mem [ROWS];

	logic [2:0]          size_c;
	logic [1:0]          pos_next;
	logic                unit_done;
	logic [MAP_LG+7:0]   cat_c;
	logic [MAP_LG-1:0]   value_c;
	logic [MAP_LG-1:0]   mask_c;
	logic [MAP_LG-1:0]   idx_c;
	logic [CMP_W-1:0]    vmax_c;
	logic [CMP_W-1:0]    limit_c;
	logic                hit;
	logic [DIST_W-1:0]   dist_next;
	logic                mem_we;
	logic [ROW_AW-1:0]   mem_wa;
	logic [ROW_W-1:0]    mem_wd;

	// effective unit size, clamped to 1..UNIT_BYTES_MAX
	always_comb begin
		size_c = {1'b0, usize_q};
		if (size_c == 3'd0) begin
			size_c = 3'd1;
		end
		if (size_c > 3'(UNIT_BYTES_MAX)) begin
			size_c = 3'(UNIT_BYTES_MAX);
		end
	end

	// value mask covering the low size bytes
	always_comb begin
		mask_c = '0;
		for (int k = 0; k < UNIT_BYTES_MAX; k++) begin
			if (3'(k) < size_c) begin
				mask_c[k*DATA_W +: DATA_W] = '1;
			end
		end
	end

	// byte packing, big-endian
	assign pos_next  = pos_q + 2'd1;
	assign unit_done = byte_valid && !stopped_q && ({1'b0, pos_next} >= size_c);
	assign cat_c     = {partial_q, data_byte};
	assign value_c   = cat_c[MAP_LG-1:0];
	assign idx_c     = value_c & mask_c;

	// distinct limit: stop_limit capped at the largest unit value, zero selects the cap
	assign vmax_c  = CMP_W'(mask_c);
	assign limit_c = ((stop_limit_q != '0) && (CMP_W'(stop_limit_q) < vmax_c)) ?
		CMP_W'(stop_limit_q) : vmax_c;

	// bitmap test on the registered row
	assign hit       = row_s1[idx_s1[ROW_LG-1:0]];
	assign dist_next = distinct_q + DIST_W'(!hit);

	// bitmap write port: clear pass or set of the new bit
	assign mem_we = cmd.insert || cmd.clear_step;
	assign mem_wa = cmd.clear_step ? clr_addr_q : idx_s1[MAP_LG-1:ROW_LG];
	assign mem_wd = cmd.clear_step ? '0 : (row_s1 | (ROW_W'(1) << idx_s1[ROW_LG-1:0]));

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && unit_done) begin
			row_s1 <= map_mem[idx_c[MAP_LG-1:ROW_LG]];
		end
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
	end

	// unit index register
	always_ff @(posedge clk) begin
		if (cmd.accept && unit_done) begin
			idx_s1 <= idx_c;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			units_processed <= processed_q;
			distinct_units  <= distinct_q;
			limit_hit       <= stopped_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usize_q      <= USIZE_W'(1);
			stop_limit_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_UNIT_SIZE) begin
				usize_q <= cfg_data[USIZE_W-1:0];
			end else if (cfg_index == REG_STOP_LIMIT) begin
				stop_limit_q <= cfg_data;
			end
		end
	end

	// stream state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pos_q       <= '0;
			processed_q <= '0;
			distinct_q  <= '0;
			stopped_q   <= 1'b0;
		end else begin
			priority if (cmd.emit) begin
				partial_q   <= '0;
				pos_q       <= '0;
				processed_q <= '0;
				distinct_q  <= '0;
				stopped_q   <= 1'b0;
			end else if (cmd.insert) begin
				distinct_q <= dist_next;
				if (processed_q != PROCESSED_SAT) begin
					processed_q <= processed_q + PROC_W'(1);
				end
				if (CMP_W'(dist_next) >= limit_c) begin
					stopped_q <= 1'b1;
				end
			end else if (cmd.accept && byte_valid && !stopped_q) begin
				if (unit_done) begin
					partial_q <= '0;
					pos_q     <= '0;
				end else begin
					partial_q <= value_c;
					pos_q     <= pos_next;
				end
			end
		end
	end

	// clear pass row counter, wraps back to zero at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + ROW_AW'(1);
		end
	end

	// result valid: set on emit, dropped on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	always_comb begin
		sts            = '0;
		sts.unit_done  = unit_done;
		sts.clear_last = (clr_addr_q == '1);
		sts.out_full   = out_valid_q;
	end

endmodule

[rtl/core/distinct_unit_counter.sv]
// distinct_unit_counter: one byte per transfer; a byte that completes no unit leaves input open,
// one that completes a unit stalls input for the bit set on the row registered by the bitmap read.
// The result is loaded in EMIT after the end marker transfer, after INSERT first if that byte completes a unit.
// Each end of stream then runs a bitmap clear pass over 2^(8*UNIT_BYTES_MAX-6) rows
// (1024 at the default), one 64-bit row per cycle, with input stalled.
// Reset is asynchronous, active low, and is followed by the same clear pass.
module distinct_unit_counter
	import duc_pkg::*;
#(
	parameter int UNIT_BYTES_MAX = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// byte input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DATA_W-1:0]    data_byte,
	input  logic                 end_of_stream,
	input  logic                 byte_valid,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PROC_W-1:0]    units_processed,
	output logic [DIST_W-1:0]    distinct_units,
	output logic                 limit_hit
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencing
	duc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.end_of_stream (end_of_stream),
		.in_stall      (in_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	// packing, bitmap and counters
	duc_datapath #(
		.UNIT_BYTES_MAX (UNIT_BYTES_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.data_byte       (data_byte),
		.byte_valid      (byte_valid),
		.cmd             (cmd),
		.sts             (sts),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.units_processed (units_processed),
		.distinct_units  (distinct_units),
		.limit_hit       (limit_hit)
	);

endmodule

[rtl/core/duc_checker.sv]
// duc_checker: port-level assertions for distinct_unit_counter, bound to the top level
// depends on duc_pkg
module duc_checker
	import duc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              end_of_stream,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PROC_W-1:0] units_processed,
	input logic [DIST_W-1:0] distinct_units,
	input logic              limit_hit
);

	logic eos_xfer;

	assign eos_xfer = in_valid && !in_stall && end_of_stream;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(units_processed)
			&& $stable(distinct_units) && $stable(limit_hit))
		else $error("result changed while stalled");

	// every distinct value came from a processed unit
	a_dist_le_proc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (PROC_W'(distinct_units) <= units_processed))
		else $error("distinct count exceeds processed count");

	// limit is at least one, so a stop means something was counted
	a_limit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_hit |-> (distinct_units != '0))
		else $error("limit hit with no distinct values");

	// end marker transfer is followed by a busy period
	a_eos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eos_xfer |=> in_stall)
		else $error("input taken right after end of stream");

	// a result appears only through EMIT after an end marker transfer, with or without INSERT
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(eos_xfer, 2) || $past(eos_xfer, 3)))
		else $error("result without end of stream");

endmodule

bind distinct_unit_counter duc_checker u_duc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.end_of_stream   (end_of_stream),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.units_processed (units_processed),
	.distinct_units  (distinct_units),
	.limit_hit       (limit_hit)
);

[sim/distinct_unit_counter_tb.sv]
// distinct_unit_counter_tb: self-checking testbench of the distinct unit counter
// a tally board predicts each end-of-stream result and checks the block's transfers against it
// depends on duc_pkg and distinct_unit_counter
module distinct_unit_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import duc_pkg::*;

	localparam int UNIT_MAX      = 2;
	localparam int MAP_SIZE      = 1 << (8 * UNIT_MAX);
	localparam int CLEAR_CYCLES  = 1 << (8 * UNIT_MAX - 6);
	localparam int SETTLE_CYCLES = CLEAR_CYCLES + 32;
	localparam int RANDOM_ITEMS  = 100;

	// one end-of-stream result
	typedef struct packed {
		logic [PROC_W-1:0] units;
		logic [DIST_W-1:0] distinct;
		logic              hit;
	} tally_t;

	// predicts results from accepted bytes and checks the block's results in order
	class distinct_tally_board;
		bit                 seen_map [MAP_SIZE];
		logic [DATA_W-1:0]  partial_byte;
		logic [1:0]         byte_pos;
		logic [PROC_W-1:0]  processed;
		logic [DIST_W-1:0]  distinct;
		logic               stopped;
		logic [USIZE_W-1:0] usize;
		logic [CFG_W-1:0]   stop_limit;
		tally_t             expected_tallies [$];
		int                 faults;

		function new();
			faults     = 0;
			usize      = USIZE_W'(1);
			stop_limit = '0;
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (seen_map[i])
				seen_map[i] = 1'b0;
			partial_byte = '0;
			byte_pos     = '0;
			processed    = '0;
			distinct     = '0;
			stopped      = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == REG_UNIT_SIZE)
				usize = value[USIZE_W-1:0];
			else if (idx == REG_STOP_LIMIT)
				stop_limit = value;
		endfunction

		// zero acts as one, anything above the maximum acts as the maximum
		function int unsigned active_size();
			int unsigned size;
			size = usize;
			if (size < 1)
				size = 1;
			if (size > UNIT_MAX)
				size = UNIT_MAX;
			return size;
		endfunction

		// set the value's bit, bump the counts, test the limit with the current registers
		function void mark_unit(int unsigned value, int unsigned size);
			int unsigned vmax;
			int unsigned limit;
			int unsigned slot;
			vmax  = (1 << (8 * size)) - 1;
			limit = vmax;
			if (stop_limit != 0 && stop_limit < vmax)
				limit = stop_limit;
			slot = value & vmax;
			if (!seen_map[slot]) begin
				seen_map[slot] = 1'b1;
				distinct = distinct + DIST_W'(1);
			end
			if (processed != PROCESSED_SAT)
				processed = processed + PROC_W'(1);
			if (distinct >= limit)
				stopped = 1'b1;
		endfunction

		// returns 1 when the transfer had any effect on the block
		function bit note_transfer(logic [DATA_W-1:0] d, logic eos, logic bv);
			int unsigned size;
			int unsigned value;
			bit          counted;
			counted = eos;
			if (bv && !stopped) begin
				counted  = 1'b1;
				size     = active_size();
				value    = {partial_byte, d};
				byte_pos = byte_pos + 2'd1;
				if (byte_pos >= size) begin
					partial_byte = '0;
					byte_pos     = '0;
					mark_unit(value, size);
				end else begin
					partial_byte = d;
				end
			end
			if (eos) begin
				expected_tallies.push_back('{processed, distinct, stopped});
				clear_stream();
			end
			return counted;
		endfunction

		function void check_result(tally_t got);
			tally_t want;
			if (expected_tallies.size() == 0) begin
				if (faults < 10)
					$display("%0t: unexpected result units=%0d distinct=%0d hit=%0b",
						$realtime, got.units, got.distinct, got.hit);
				faults++;
				return;
			end
			want = expected_tallies.pop_front();
			if (got.units !== want.units || got.distinct !== want.distinct ||
					got.hit !== want.hit) begin
				if (faults < 10)
					$display("%0t: mismatch exp=%0d/%0d/%0b got=%0d/%0d/%0b",
						$realtime, want.units, want.distinct, want.hit,
						got.units, got.distinct, got.hit);
				faults++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [DATA_W-1:0]    data_byte;
	logic                 end_of_stream;
	logic                 byte_valid;
	logic                 out_valid;
	logic                 out_stall;
	logic [PROC_W-1:0]    units_processed;
	logic [DIST_W-1:0]    distinct_units;
	logic                 limit_hit;

	distinct_tally_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int counted_items = 0;

	distinct_unit_counter #(
		.UNIT_BYTES_MAX(UNIT_MAX)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_stream  (end_of_stream),
		.byte_valid     (byte_valid),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.units_processed(units_processed),
		.distinct_units (distinct_units),
		.limit_hit      (limit_hit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			board.check_result('{units_processed, distinct_units, limit_hit});
	end

	// one input transfer, with random sender gaps in front of it
	task automatic send_item(input logic [DATA_W-1:0] d, input logic eos, input logic bv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= d;
		end_of_stream <= eos;
		byte_valid    <= bv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (board.note_transfer(d, eos, bv))
			counted_items++;
	endtask

	// wait for all results and the bitmap clear pass that follows
	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_tallies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back; only while idle
	task automatic write_config(input logic [CFG_W-1:0] size_val,
			input logic [CFG_W-1:0] limit_val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_UNIT_SIZE;
		cfg_data  <= size_val;
		@(posedge clk);
		board.write_reg(REG_UNIT_SIZE, size_val);
		cfg_index <= REG_STOP_LIMIT;
		cfg_data  <= limit_val;
		@(posedge clk);
		board.write_reg(REG_STOP_LIMIT, limit_val);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_items();
		// default size 1, duplicate value, ignored empty item, byte with end marker
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);
		// bare end marker on an empty stream
		send_item(8'h00, 1'b1, 1'b0);
		// two-byte units, stop limit of two, bytes after the stop are ignored
		write_config(16'hfffe, 16'd2);
		send_item(8'h12, 1'b0, 1'b1);
		send_item(8'h34, 1'b0, 1'b1);
		send_item(8'h12, 1'b0, 1'b1);
		send_item(8'h34, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h55, 1'b1, 1'b1);
		// oversize unit acts as two bytes, trailing partial unit dropped
		write_config(16'h0003, 16'd0);
		send_item(8'hab, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		// zero size acts as one byte, limit above the value range is capped
		write_config(16'h0000, 16'hffff);
		send_item(8'h7f, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b1);
		// limit of one stops on the first unit
		write_config(16'h0001, 16'h0001);
		send_item(8'h3c, 1'b0, 1'b1);
		send_item(8'hc3, 1'b1, 1'b1);
	endtask

	// every value of the unit range at least once, so a limit at the value cap is reached
	task automatic sweep_values(input int unsigned size, input logic [CFG_W-1:0] limit_val);
		int unsigned span;
		int unsigned offset;
		int unsigned value;
		span   = 1 << (8 * size);
		offset = $urandom_range(span - 1);
		write_config(CFG_W'(size), limit_val);
		for (int unsigned i = 0; i < span + 2; i++) begin
			value = (i * 40503 + offset) & (span - 1);
			if (size == 2)
				send_item(value[15:8], 1'b0, 1'b1);
			send_item(value[7:0], 1'b0, 1'b1);
		end
		send_item(8'h00, 1'b1, 1'b0);
	endtask

	task automatic pick_config();
		logic [CFG_W-1:0] size_val;
		logic [CFG_W-1:0] limit_val;
		size_val = CFG_W'($urandom_range(16'hffff));
		case ($urandom_range(6))
			0:       limit_val = '0;
			1:       limit_val = CFG_W'($urandom_range(1, 16));
			2:       limit_val = CFG_W'($urandom_range(1, 6));
			3:       limit_val = 16'd255;
			4:       limit_val = 16'd256;
			5:       limit_val = 16'hffff;
			default: limit_val = CFG_W'($urandom_range(16'hffff));
		endcase
		write_config(size_val, limit_val);
	endtask

	// byte runs from a narrow or the full value pool, some empty items, random end kind
	task automatic random_stream();
		int unsigned len;
		int unsigned pool;
		logic [DATA_W-1:0] pattern;
		logic [DATA_W-1:0] d;
		logic eos;
		logic bv;
		len     = $urandom_range(1, 40);
		pool    = $urandom_range(1) ? $urandom_range(1, 12) : 256;
		pattern = DATA_W'($urandom_range(255));
		for (int unsigned i = 0; i < len; i++) begin
			eos = (i == len - 1);
			bv  = eos ? ($urandom_range(3) != 0) : ($urandom_range(9) != 0);
			d   = (pool == 256) ? DATA_W'($urandom_range(255)) :
				(DATA_W'($urandom_range(pool - 1)) ^ pattern);
			send_item(d, eos, bv);
		end
	endtask

	task automatic random_phase();
		int start;
		start = counted_items;
		while (counted_items - start < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 40)
				pick_config();
			random_stream();
		end
	endtask

	// stimulus
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_UNIT_SIZE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		data_byte     <= '0;
		end_of_stream <= 1'b0;
		byte_valid    <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// sender gaps light, receiver stalls heavy
		send_idle_pct  = 26;
		recv_stall_pct = 51;
		directed_items();
		random_phase();

		// the other way round
		send_idle_pct  = 51;
		recv_stall_pct = 26;
		sweep_values(1, 16'd300);
		random_phase();

		// no idling at all
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_phase();

		in_valid <= 1'b0;
		while (board.expected_tallies.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (board.faults == 0 && board.expected_tallies.size() == 0)
			$display("distinct_unit_counter regression: pass");
		else
			$display("distinct_unit_counter regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("distinct_unit_counter regression: fail");
		$finish;
	end

endmodule
